// ----- design/qrs_pkg.sv -----
// Shared status codes and mode constant for the quadratic root solver.
package qrs_pkg;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_COMPLEX = 2'd1;
	localparam logic [1:0] ST_A_ZERO  = 2'd2;
	localparam logic [1:0] ST_SAT     = 2'd3;
	localparam logic       MODE_MINUS = 1'b0;
endpackage

// ----- design/qrs_disc.sv -----
// Discriminant front end: magnitudes, products, b*b - 4ac, in three stages.
module qrs_disc #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	input  logic [W-1:0]     c,
	input  logic             mode,
	output logic             out_valid,
	output logic [2*W+1:0]   disc,
	output logic             cplx,
	output logic             zero_a,
	output logic             na,
	output logic             nb,
	output logic             mode_o,
	output logic [W-1:0]     ma,
	output logic [W-1:0]     mb
);
	logic         v_s1, v_s2, v_s3;
	logic [W-1:0] ma_s1, mb_s1, mc_s1, ma_s2, mb_s2, ma_s3, mb_s3;
	logic         na_s1, nb_s1, nc_s1, md_s1, na_s2, nb_s2, nc_s2, md_s2;
	logic         na_s3, nb_s3, md_s3, za_s3, cx_s3;
	logic [2*W-1:0] bb_s2, ac_s2;
	logic [2*W+1:0] disc_s3, bbx, ac4;

	assign bbx = {2'b00, bb_s2};
	assign ac4 = {ac_s2, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s1 <= a[W-1];
			nb_s1 <= b[W-1];
			nc_s1 <= c[W-1];
			md_s1 <= mode;
			ma_s1 <= a[W-1] ? (~a + 1'b1) : a;
			mb_s1 <= b[W-1] ? (~b + 1'b1) : b;
			mc_s1 <= c[W-1] ? (~c + 1'b1) : c;
			bb_s2 <= (2*W)'(mb_s1) * (2*W)'(mb_s1);
			ac_s2 <= (2*W)'(ma_s1) * (2*W)'(mc_s1);
			ma_s2 <= ma_s1;
			mb_s2 <= mb_s1;
			na_s2 <= na_s1;
			nb_s2 <= nb_s1;
			nc_s2 <= nc_s1;
			md_s2 <= md_s1;
			if (na_s2 != nc_s2) begin
				disc_s3 <= bbx + ac4;
				cx_s3   <= 1'b0;
			end else begin
				disc_s3 <= bbx - ac4;
				cx_s3   <= (ac4 > bbx);
			end
			za_s3 <= (ma_s2 == '0);
			ma_s3 <= ma_s2;
			mb_s3 <= mb_s2;
			na_s3 <= na_s2;
			nb_s3 <= nb_s2;
			md_s3 <= md_s2;
		end
	end

	assign out_valid = v_s3;
	assign disc      = disc_s3;
	assign cplx      = cx_s3;
	assign zero_a    = za_s3;
	assign na        = na_s3;
	assign nb        = nb_s3;
	assign mode_o    = md_s3;
	assign ma        = ma_s3;
	assign mb        = mb_s3;
endmodule

// ----- design/qrs_sqrt.sv -----
// Integer square root, one result bit per pipeline stage, sideband carried along.
module qrs_sqrt #(
	parameter int N  = 33,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [2*N-1:0] v,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [N-1:0]  root,
	output logic [SW-1:0] side_out
);
	logic           vld_r  [N];
	logic [N+1:0]   rem_r  [N];
	logic [N-1:0]   rt_r   [N];
	logic [2*N-1:0] val_r  [N];
	logic [SW-1:0]  sd_r   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic           vi;
		logic [N+1:0]   ri, t, tr;
		logic [N-1:0]   qi;
		logic [2*N-1:0] xi;
		logic [SW-1:0]  si;
		logic           ge;
		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign ri = '0;
			assign qi = '0;
			assign xi = v;
			assign si = side_in;
		end else begin : g_next
			assign vi = vld_r[k-1];
			assign ri = rem_r[k-1];
			assign qi = rt_r[k-1];
			assign xi = val_r[k-1];
			assign si = sd_r[k-1];
		end
		assign t  = {ri[N-1:0], xi[2*N-1 -: 2]};
		assign tr = {qi, 2'b01};
		assign ge = (t >= tr);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r[k] <= 1'b0;
			end else if (adv) begin
				vld_r[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_r[k] <= ge ? (t - tr) : t;
				rt_r[k]  <= {qi[N-2:0], ge};
				val_r[k] <= {xi[2*N-3:0], 2'b00};
				sd_r[k]  <= si;
			end
		end
	end

	assign out_valid = vld_r[N-1];
	assign root      = rt_r[N-1];
	assign side_out  = sd_r[N-1];
endmodule

// ----- design/qrs_div.sv -----
// Restoring unsigned divider, one quotient bit per pipeline stage.
module qrs_div #(
	parameter int NW = 50,
	parameter int DW = 33,
	parameter int SW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic          vld_r [NW];
	logic [DW-1:0] rem_r [NW];
	logic [NW-1:0] q_r   [NW];
	logic [NW-1:0] n_r   [NW];
	logic [DW-1:0] d_r   [NW];
	logic [SW-1:0] sd_r  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          vi, ge;
		logic [DW-1:0] ri, di;
		logic [NW-1:0] qi, ni;
		logic [SW-1:0] si;
		logic [DW:0]   t, sub;
		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign ri = '0;
			assign qi = '0;
			assign ni = num;
			assign di = den;
			assign si = side_in;
		end else begin : g_next
			assign vi = vld_r[k-1];
			assign ri = rem_r[k-1];
			assign qi = q_r[k-1];
			assign ni = n_r[k-1];
			assign di = d_r[k-1];
			assign si = sd_r[k-1];
		end
		assign t   = {ri, ni[NW-1]};
		assign sub = t - {1'b0, di};
		assign ge  = (t >= {1'b0, di});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r[k] <= 1'b0;
			end else if (adv) begin
				vld_r[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_r[k] <= ge ? sub[DW-1:0] : t[DW-1:0];
				q_r[k]   <= {qi[NW-2:0], ge};
				n_r[k]   <= {ni[NW-2:0], 1'b0};
				d_r[k]   <= di;
				sd_r[k]  <= si;
			end
		end
	end

	assign out_valid = vld_r[NW-1];
	assign quo       = q_r[NW-1];
	assign side_out  = sd_r[NW-1];
endmodule

// ----- design/quadratic_root_solver.sv -----
// Top level of the quadratic root solver: stream ports, numerator stage, output register.
// One root of a*x^2 + b*x + c = 0 per transfer, in signed fixed point with FRAC_BITS
// fraction bits. The block is a single pipeline that takes a new coefficient set every
// cycle while the pipeline advances; it is built from three stages for the discriminant,
// one per bit of the square root, one for the numerator, one per quotient bit of the
// divider, and the output register.
// The whole pipeline advances whenever the output register is empty or being taken, so
// a stall on the master side holds every stage and nothing is dropped or repeated.
// a equal to zero returns root 0 with status 2, a negative discriminant root 0 with
// status 1, an out-of-range quotient the saturated limit with status 3.
module quadratic_root_solver #(
	parameter int COEF_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// coef_a, coef_b, coef_c from bit 0 up, zero padded to bytes
	input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
	// mode
	input  logic [0:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// root, zero padded to bytes
	output logic [((COEF_WIDTH+7)/8)*8-1:0] m_tdata,
	// status
	output logic [1:0] m_tuser
);
	import qrs_pkg::*;

	localparam int W   = COEF_WIDTH;
	localparam int N   = W + 1;
	localparam int SSW = 2 * W + 5;
	localparam int NMW = W + 2;
	localparam int QW  = NMW + FRAC_BITS;
	localparam int ODW = ((W + 7) / 8) * 8;

	logic adv;

	// discriminant stages
	logic           dv, dcx, dza, dna, dnb, dmd;
	logic [2*W+1:0] disc;
	logic [W-1:0]   dma, dmb;

	// square root stages
	logic           rv;
	logic [N-1:0]   d;
	logic [SSW-1:0] sq_side_in, sq_side;
	logic           r_za, r_cx, r_na, r_nb, r_md;
	logic [W-1:0]   r_ma, r_mb;

	// numerator stage
	logic           v_n1, za_n1, cx_n1, na_n1, nn_n1;
	logic [NMW-1:0] nm_n1;
	logic [W-1:0]   ma_n1;
	logic           n1, n2, nn;
	logic [NMW-1:0] nm, mbx, dx;

	// divider stages
	logic          qv;
	logic [QW-1:0] q;
	logic [3:0]    dv_side;
	logic          q_za, q_cx, q_na, q_nn;

	// output register
	logic          neg, sat;
	logic [QW-1:0] lim, lim_sel;
	logic          m_tvalid_q;
	logic [W-1:0]  root_q;
	logic [1:0]    status_q;

	// everything moves when the output slot is free or drains this cycle
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	qrs_disc #(.W(W)) u_disc (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.a        (s_tdata[W-1:0]),
		.b        (s_tdata[2*W-1:W]),
		.c        (s_tdata[3*W-1:2*W]),
		.mode     (s_tuser[0]),
		.out_valid(dv),
		.disc     (disc),
		.cplx     (dcx),
		.zero_a   (dza),
		.na       (dna),
		.nb       (dnb),
		.mode_o   (dmd),
		.ma       (dma),
		.mb       (dmb)
	);

	assign sq_side_in = {dza, dcx, dna, dnb, dmd, dma, dmb};

	qrs_sqrt #(.N(N), .SW(SSW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (dv),
		.v        (disc),
		.side_in  (sq_side_in),
		.out_valid(rv),
		.root     (d),
		.side_out (sq_side)
	);

	assign {r_za, r_cx, r_na, r_nb, r_md, r_ma, r_mb} = sq_side;

	// numerator -b +/- d in sign-magnitude
	assign mbx = {2'b00, r_mb};
	assign dx  = {1'b0, d};
	always_comb begin
		n1 = !r_nb && (r_mb != '0);
		n2 = (r_md == MODE_MINUS) && (d != '0);
		if (n1 == n2) begin
			nm = mbx + dx;
			nn = n1;
		end else if (mbx >= dx) begin
			nm = mbx - dx;
			nn = n1;
		end else begin
			nm = dx - mbx;
			nn = n2;
		end
		if (nm == '0) begin
			nn = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n1 <= 1'b0;
		end else if (adv) begin
			v_n1 <= rv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_n1 <= nm;
			nn_n1 <= nn;
			ma_n1 <= r_ma;
			za_n1 <= r_za;
			cx_n1 <= r_cx;
			na_n1 <= r_na;
		end
	end

	// den 2|a| is zero only when a is zero, whose quotient is discarded
	qrs_div #(.NW(QW), .DW(W + 1), .SW(4)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_n1),
		.num      ({nm_n1, {FRAC_BITS{1'b0}}}),
		.den      ({ma_n1, 1'b0}),
		.side_in  ({za_n1, cx_n1, na_n1, nn_n1}),
		.out_valid(qv),
		.quo      (q),
		.side_out (dv_side)
	);

	assign {q_za, q_cx, q_na, q_nn} = dv_side;

	// sign of the quotient, then saturation against the signed limits
	assign neg     = (q_nn != q_na) && (q != '0);
	assign lim     = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
	assign lim_sel = neg ? lim : (lim - 1'b1);
	assign sat     = (q > lim_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= qv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_za) begin
				root_q   <= '0;
				status_q <= ST_A_ZERO;
			end else if (q_cx) begin
				root_q   <= '0;
				status_q <= ST_COMPLEX;
			end else if (sat) begin
				root_q   <= lim_sel[W-1:0];
				status_q <= ST_SAT;
			end else begin
				root_q   <= neg ? (~q[W-1:0] + 1'b1) : q[W-1:0];
				status_q <= ST_OK;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(ODW-W){1'b0}}, root_q};
	assign m_tuser  = status_q;
endmodule
